FILE: src/tpts_pkg.sv
// ----------------------------------------------------------------------------
// Track pair target stabilizer package
// Shared constants, the sequencer state type and the multiplier request type.
// ----------------------------------------------------------------------------
package tpts_pkg;

    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_LIMIT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_DEADBAND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_GAIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_LIMIT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CONS_THRESHOLD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CONS_BLEND     = 3'd7;

    localparam logic signed [35:0] TURN_GAP       = 36'sd65536;
    localparam logic signed [35:0] HALF_UNIT      = 36'sd32768;
    localparam logic [15:0] DRIFT_DECAY = 16'd65208;
    localparam logic [15:0] STOP_DECAY  = 16'd58982;
    localparam logic [15:0] TURN_DECAY  = 16'd64225;
    localparam logic [15:0] HALF_GAIN   = 16'd32768;

    localparam logic signed [35:0] S32_MAX = 36'sh07FFFFFFF;
    localparam logic signed [35:0] S32_MIN = -36'sh080000000;

    // one-hot sequencer states
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_YAWD  = 9'b000000010,
        ST_STOPD = 9'b000000100,
        ST_TURND = 9'b000001000,
        ST_YAWC  = 9'b000010000,
        ST_LOADC = 9'b000100000,
        ST_CONS  = 9'b001000000,
        ST_FIN   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    // request to the shared scaler: |x| * f >> 16, sign of x kept
    typedef struct packed {
        logic signed [35:0] x;
        logic [15:0]        f;
    } scale_req_t;

    function automatic logic signed [35:0] sat32(input logic signed [35:0] x);
        logic signed [35:0] r;
        begin
            r = x;
            if (x > S32_MAX) r = S32_MAX;
            if (x < S32_MIN) r = S32_MIN;
            return r;
        end
    endfunction

    function automatic logic signed [35:0] abs36(input logic signed [35:0] x);
        return x[35] ? -x : x;
    endfunction

endpackage

FILE: src/tpts_if.sv
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying a packed payload.
// ----------------------------------------------------------------------------
interface tpts_if #(parameter int unsigned W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/track_pair_target_stabilizer_unit.sv
// ----------------------------------------------------------------------------
// Track pair target stabilizer
// Drift, load and consensus correction of a pair of track targets.
// ----------------------------------------------------------------------------
// A soft reset goes from idle straight to the final state; a tick steps through
// the drift, load and consensus states, with a second pass through the final
// state when the consensus filter fires. The single shared scaler serves every step.
// Input is not ready until the result is taken.
// Reset clears drift_reg to zero and the registers to their defaults.
module track_pair_target_stabilizer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    tpts_if.sink        in_ch,
    tpts_if.source      out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    logic [30:0] cfg_reg [8];
    logic busy, done;
    logic [129:0] result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0] <= 31'd328;
            cfg_reg[1] <= 31'd131072;
            cfg_reg[2] <= 31'd327680;
            cfg_reg[3] <= 31'd655360;
            cfg_reg[4] <= 31'd655;
            cfg_reg[5] <= 31'd131072;
            cfg_reg[6] <= 31'd1310720;
            cfg_reg[7] <= 31'd13107;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tpts_pkg::REG_YAW_GAIN:       cfg_reg[0] <= {15'd0, cfg_data[15:0]};
                tpts_pkg::REG_YAW_LIMIT:      cfg_reg[1] <= cfg_data;
                tpts_pkg::REG_YAW_DEADBAND:   cfg_reg[2] <= cfg_data;
                tpts_pkg::REG_LOAD_THRESHOLD: cfg_reg[3] <= cfg_data;
                tpts_pkg::REG_LOAD_GAIN:      cfg_reg[4] <= {15'd0, cfg_data[15:0]};
                tpts_pkg::REG_LOAD_LIMIT:     cfg_reg[5] <= cfg_data;
                tpts_pkg::REG_CONS_THRESHOLD: cfg_reg[6] <= cfg_data;
                tpts_pkg::REG_CONS_BLEND:     cfg_reg[7] <= {15'd0, cfg_data[15:0]};
                default: ;
            endcase
        end
    end

    assign in_ch.ready = !busy;

    tpts_core u_core (
        .clk(clk), .rst_n(rst_n),
        .start(in_ch.valid && !busy),
        .item(in_ch.data),
        .cfg_words(cfg_reg),
        .busy(busy), .done(done), .result(result),
        .taken(out_ch.ready)
    );

    assign out_ch.valid = done;
    assign out_ch.data = result;
endmodule

FILE: src/tpts_scaler.sv
// ----------------------------------------------------------------------------
// Shared scaler
// Signed magnitude times Q0.16 factor, truncated toward zero; registered.
// ----------------------------------------------------------------------------
module tpts_scaler
(
    input  logic                   clk,
    input  tpts_pkg::scale_req_t   req,
    output logic signed [35:0]     res
);
    logic [35:0] mag;
    logic [51:0] prod;
    logic signed [35:0] res_reg;
    logic signed [35:0] res_next;

    always_comb
    begin
        mag = 36'(tpts_pkg::abs36(req.x));
        prod = 52'(mag) * 52'(req.f);
        res_next = req.x[35] ? -$signed(prod[51:16]) : $signed(prod[51:16]);
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;
endmodule

FILE: src/tpts_core.sv
// ----------------------------------------------------------------------------
// Stabilizer sequencer
// Steps one tick or soft reset through the shared scaler and builds the biases.
// ----------------------------------------------------------------------------
module tpts_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [192:0]       item,
    input  logic [30:0]        cfg_words [8],
    output logic               busy,
    output logic               done,
    output logic [129:0]       result,
    input  logic               taken
);
    typedef logic signed [35:0] s36_t;

    tpts_pkg::state_t state_reg, state_next;
    tpts_pkg::scale_req_t req;
    s36_t sres;
    s36_t drift_reg, drift_next;
    s36_t bl_reg, bl_next, br_reg, br_next;
    s36_t sl_reg, sr_reg, ll_reg, lr_reg, gl_reg, gr_reg;
    logic cmd_reg, turn_reg, mov_reg, stop_reg, bounce_reg, bounce_next;
    logic [129:0] res_reg, res_next;
    s36_t dsum, dmag, lmag, ld, sd, lim, blc, brc, gbl, gbr, corr, adjl, adjr;
    logic rpick;

    tpts_scaler u_scaler (.clk(clk), .req(req), .res(sres));

    function automatic s36_t guard(input s36_t g, input s36_t b);
        s36_t n;
        s36_t h;
        begin
            n = g + b;
            h = g >>> 1;
            if (g[35] && (g[0])) h = h + 36'sd1;
            if ((g > tpts_pkg::HALF_UNIT && n < 0) || (g < -tpts_pkg::HALF_UNIT && n > 0))
                return -h;
            return b;
        end
    endfunction

    function automatic s36_t clampl(input s36_t x, input s36_t l);
        if (x > l) return l;
        if (x < -l) return -l;
        return x;
    endfunction

    // decisions taken from the incoming item
    function automatic logic turn_in();
        s36_t a;
        a = tpts_pkg::abs36(s36_t'($signed(item[63:32])) - s36_t'($signed(item[31:0])));
        return a > tpts_pkg::TURN_GAP;
    endfunction

    function automatic logic big_in();
        s36_t a;
        s36_t b;
        a = tpts_pkg::abs36(s36_t'($signed(item[63:32])));
        b = tpts_pkg::abs36(s36_t'($signed(item[31:0])));
        return (a > tpts_pkg::HALF_UNIT) || (b > tpts_pkg::HALF_UNIT);
    endfunction

    function automatic logic mov_in();
        return !turn_in() && big_in();
    endfunction

    function automatic logic stop_in();
        return !big_in();
    endfunction

    always_comb
    begin
        dsum = tpts_pkg::sat32(drift_reg + (sl_reg - sr_reg));
        dmag = tpts_pkg::abs36(sres);
        ld = ll_reg - lr_reg;
        lmag = tpts_pkg::abs36(ld);
        sd = sl_reg - sr_reg;
        rpick = !(tpts_pkg::abs36(sl_reg - gl_reg) > tpts_pkg::abs36(sr_reg - gr_reg));
        lim = (cfg_words[1] > cfg_words[5]) ? s36_t'(cfg_words[1]) : s36_t'(cfg_words[5]);
        req.x = '0;
        req.f = '0;
        state_next = state_reg;
        drift_next = drift_reg;
        bl_next = bl_reg;
        br_next = br_reg;
        bounce_next = bounce_reg;
        res_next = res_reg;
        corr = '0;
        blc = clampl(bl_reg, lim);
        brc = clampl(br_reg, lim);
        gbl = guard(gl_reg, blc);
        gbr = guard(gr_reg, brc);
        adjl = tpts_pkg::sat32(gl_reg + gbl);
        adjr = tpts_pkg::sat32(gr_reg + gbr);
        case (state_reg)
            tpts_pkg::ST_IDLE:
            begin
                bl_next = '0;
                br_next = '0;
                bounce_next = 1'b0;
                if (start)
                begin
                    req.x = drift_reg;
                    req.f = tpts_pkg::HALF_GAIN;
                    if (item[192]) state_next = tpts_pkg::ST_FIN;
                    else if (mov_in()) state_next = tpts_pkg::ST_YAWD;
                    else if (stop_in()) state_next = tpts_pkg::ST_STOPD;
                    else state_next = tpts_pkg::ST_TURND;
                end
            end
            tpts_pkg::ST_YAWD:
            begin
                req.x = dsum;
                req.f = tpts_pkg::DRIFT_DECAY;
                state_next = tpts_pkg::ST_YAWC;
            end
            tpts_pkg::ST_YAWC:
            begin
                drift_next = sres;
                // scale excess drift by gain, sign fixed after
                req.x = dmag - s36_t'(cfg_words[2]);
                req.f = cfg_words[0][15:0];
                state_next = tpts_pkg::ST_LOADC;
            end
            tpts_pkg::ST_STOPD:
            begin
                req.x = drift_reg;
                req.f = tpts_pkg::STOP_DECAY;
                state_next = tpts_pkg::ST_TURND;
            end
            tpts_pkg::ST_TURND:
            begin
                if (stop_reg) drift_next = sres;
                req.x = stop_reg ? sres : drift_reg;
                req.f = turn_reg ? tpts_pkg::TURN_DECAY : 16'hFFFF;
                state_next = tpts_pkg::ST_LOADC;
            end
            tpts_pkg::ST_LOADC:
            begin
                if (mov_reg)
                begin
                    if (tpts_pkg::abs36(drift_reg) > s36_t'(cfg_words[2]))
                    begin
                        corr = (sres > s36_t'(cfg_words[1])) ? s36_t'(cfg_words[1]) : sres;
                        if (drift_reg > 0)
                        begin
                            bl_next = -corr;
                            br_next = corr;
                        end
                        else
                        begin
                            bl_next = corr;
                            br_next = -corr;
                        end
                    end
                end
                else if (turn_reg) drift_next = sres;
                req.x = lmag - s36_t'(cfg_words[3]);
                req.f = cfg_words[4][15:0];
                state_next = tpts_pkg::ST_CONS;
            end
            tpts_pkg::ST_CONS:
            begin
                if (lmag > s36_t'(cfg_words[3]))
                begin
                    corr = (sres > s36_t'(cfg_words[5])) ? s36_t'(cfg_words[5]) : sres;
                    if (turn_reg) corr = corr >>> 1;
                    if (ld > 0) br_next = br_reg - corr;
                    else bl_next = bl_reg - corr;
                end
                req.x = rpick ? sd : -sd;
                req.f = cfg_words[7][15:0];
                state_next = tpts_pkg::ST_FIN;
            end
            tpts_pkg::ST_FIN:
            begin
                if (cmd_reg)
                begin
                    drift_next = sres;
                    res_next = {gl_reg[31:0], gr_reg[31:0], 64'd0, 2'b00};
                    state_next = tpts_pkg::ST_OUT;
                end
                else if (mov_reg && !bounce_reg &&
                         tpts_pkg::abs36(sd) > s36_t'(cfg_words[6]))
                begin
                    // fold in the blend, then one more pass here to finish
                    bounce_next = 1'b1;
                    if (rpick) br_next = br_reg + sres;
                    else bl_next = bl_reg + sres;
                end
                else
                begin
                    res_next = {adjl[31:0], adjr[31:0],
                                gbl[31:0], gbr[31:0], turn_reg, bounce_reg};
                    state_next = tpts_pkg::ST_OUT;
                end
            end
            tpts_pkg::ST_OUT:
            begin
                if (taken) state_next = tpts_pkg::ST_IDLE;
            end
            default: state_next = tpts_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpts_pkg::ST_IDLE;
            drift_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            drift_reg <= drift_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bl_reg <= bl_next;
        br_reg <= br_next;
        bounce_reg <= bounce_next;
        res_reg <= res_next;
        if (state_reg == tpts_pkg::ST_IDLE && start)
        begin
            cmd_reg <= item[192];
            sl_reg <= s36_t'($signed(item[191:160]));
            sr_reg <= s36_t'($signed(item[159:128]));
            ll_reg <= s36_t'($signed(item[127:96]));
            lr_reg <= s36_t'($signed(item[95:64]));
            gl_reg <= s36_t'($signed(item[63:32]));
            gr_reg <= s36_t'($signed(item[31:0]));
            turn_reg <= turn_in();
            mov_reg <= mov_in();
            stop_reg <= stop_in();
        end
    end

    assign busy = (state_reg != tpts_pkg::ST_IDLE);
    assign done = (state_reg == tpts_pkg::ST_OUT);
    assign result = res_reg;

`ifndef SYNTHESIS
    a_drift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (drift_reg <= tpts_pkg::S32_MAX) && (drift_reg >= tpts_pkg::S32_MIN))
        else $error("drift out of range");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        done && !taken |=> done && $stable(result))
        else $error("result changed while waiting");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("start not taken");
`endif
endmodule

FILE: tb/sv/tb_track_pair_target_stabilizer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Track pair target stabilizer testbench
// Drives control ticks and soft resets through the input channel, computes the
// corrected targets with an independent drift/load/consensus predictor, and
// compares every result transfer field by field under random idling on both
// channels and several register settings.
// ----------------------------------------------------------------------------
module tb_track_pair_target_stabilizer_unit;

    localparam int IN_W  = 193;
    localparam int OUT_W = 130;
    localparam int IDLE_LIMIT = 20000;
    localparam longint Q_HALF    = 32768;
    localparam longint Q_TURN    = 65536;
    localparam longint DEC_YAW   = 65208;
    localparam longint DEC_STOP  = 58982;
    localparam longint DEC_TURN  = 64225;
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_SOFTRST = 1'b1;

    typedef struct {
        logic signed [31:0] adj_l;
        logic signed [31:0] adj_r;
        logic signed [31:0] off_l;
        logic signed [31:0] off_r;
        logic               turn;
        logic               bounce;
    } target_res_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [30:0] cfg_data;

    tpts_if #(.W(IN_W))  in_ch();
    tpts_if #(.W(OUT_W)) out_ch();

    track_pair_target_stabilizer_unit u_top (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    target_res_t pending_targets[$];
    longint      drift_acc;
    longint      regs[8];
    int          err_count = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          steady;   // no idling on either side

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ---------------------------------------------------------------- predictor
    function automatic longint mag_of(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint scale_q16(longint x, longint f);
        longint p;
        p = (mag_of(x) * f) >> 16;
        return x < 0 ? -p : p;
    endfunction

    function automatic longint sat_s32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    // bias may not reverse a goal's direction
    function automatic longint keep_direction(longint g, longint b);
        longint n;
        n = g + b;
        if ((g > Q_HALF && n < 0) || (g < -Q_HALF && n > 0))
            return -scale_q16(g, 32768);
        return b;
    endfunction

    function automatic target_res_t stabilize(logic cmd, longint sl, longint sr,
                                              longint ll, longint lr,
                                              longint gl, longint gr);
        target_res_t r;
        longint bl, br, gmax, m, c, d, lim;
        bit turning, moving, bounce;
        bl = 0; br = 0; bounce = 0;
        if (cmd == CMD_SOFTRST) begin
            drift_acc = scale_q16(drift_acc, 32768);
            r.adj_l = 32'(gl); r.adj_r = 32'(gr); r.off_l = 0; r.off_r = 0;
            r.turn = 0; r.bounce = 0;
            return r;
        end
        turning = mag_of(gl - gr) > Q_TURN;
        gmax = mag_of(gl) > mag_of(gr) ? mag_of(gl) : mag_of(gr);
        moving = !turning && gmax > Q_HALF;
        if (moving) begin
            drift_acc = sat_s32(drift_acc + (sl - sr));
            drift_acc = scale_q16(drift_acc, DEC_YAW);
            m = mag_of(drift_acc);
            if (m > regs[tpts_pkg::REG_YAW_DEADBAND]) begin
                c = clip(scale_q16(m - regs[tpts_pkg::REG_YAW_DEADBAND],
                                   regs[tpts_pkg::REG_YAW_GAIN]),
                         0, regs[tpts_pkg::REG_YAW_LIMIT]);
                if (drift_acc > 0) begin bl -= c; br += c; end
                else begin bl += c; br -= c; end
            end
        end else if (gmax <= Q_HALF) begin
            drift_acc = scale_q16(drift_acc, DEC_STOP);
        end
        if (turning)
            drift_acc = scale_q16(drift_acc, DEC_TURN);
        d = ll - lr;
        if (mag_of(d) > regs[tpts_pkg::REG_LOAD_THRESHOLD]) begin
            c = clip(scale_q16(mag_of(d) - regs[tpts_pkg::REG_LOAD_THRESHOLD],
                               regs[tpts_pkg::REG_LOAD_GAIN]),
                     0, regs[tpts_pkg::REG_LOAD_LIMIT]);
            if (turning) c = c >>> 1;
            if (d > 0) br -= c;
            else bl -= c;
        end
        if (moving) begin
            d = sl - sr;
            if (mag_of(d) > regs[tpts_pkg::REG_CONS_THRESHOLD]) begin
                if (mag_of(sl - gl) > mag_of(sr - gr))
                    bl += scale_q16(-d, regs[tpts_pkg::REG_CONS_BLEND]);
                else
                    br += scale_q16(d, regs[tpts_pkg::REG_CONS_BLEND]);
                bounce = 1;
            end
        end
        lim = regs[tpts_pkg::REG_YAW_LIMIT] > regs[tpts_pkg::REG_LOAD_LIMIT]
              ? regs[tpts_pkg::REG_YAW_LIMIT] : regs[tpts_pkg::REG_LOAD_LIMIT];
        bl = keep_direction(gl, clip(bl, -lim, lim));
        br = keep_direction(gr, clip(br, -lim, lim));
        r.adj_l = 32'(sat_s32(gl + bl));
        r.adj_r = 32'(sat_s32(gr + br));
        r.off_l = 32'(bl);
        r.off_r = 32'(br);
        r.turn = turning;
        r.bounce = bounce;
        return r;
    endfunction

    // ---------------------------------------------------------------- checking
    task automatic report_mismatch(string what, longint got, longint want);
        err_count++;
        if (err_count <= 30)
            $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge clk) begin
        target_res_t w;
        logic [OUT_W-1:0] p;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            p = out_ch.data;
            if (pending_targets.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                w = pending_targets.pop_front();
                if ($signed(p[129:98]) !== w.adj_l)
                    report_mismatch("adjusted_l", $signed(p[129:98]), w.adj_l);
                if ($signed(p[97:66]) !== w.adj_r)
                    report_mismatch("adjusted_r", $signed(p[97:66]), w.adj_r);
                if ($signed(p[65:34]) !== w.off_l)
                    report_mismatch("offset_l", $signed(p[65:34]), w.off_l);
                if ($signed(p[33:2]) !== w.off_r)
                    report_mismatch("offset_r", $signed(p[33:2]), w.off_r);
                if (p[1] !== w.turn)
                    report_mismatch("is_turning", p[1], w.turn);
                if (p[0] !== w.bounce)
                    report_mismatch("bounce_seen", p[0], w.bounce);
            end
        end
    end

    // receiver stalls: mostly short, a few long
    always @(posedge clk) begin
        if (steady || stall_left == 0) begin
            out_ch.ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 20)
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 3);
        end else begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_track_pair_target_stabilizer_unit: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    function automatic int pick_gap();
        int k;
        if (steady) return 0;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic send_tick(logic cmd, longint sl, longint sr, longint ll,
                             longint lr, longint gl, longint gr);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.data <= {cmd, 32'(sl), 32'(sr), 32'(ll), 32'(lr), 32'(gl), 32'(gr)};
        do @(posedge clk); while (!in_ch.ready);
        pending_targets.push_back(stabilize(cmd, 32'(sl) == 0 ? 0 : longint'($signed(32'(sl))),
                                            longint'($signed(32'(sr))),
                                            longint'($signed(32'(ll))),
                                            longint'($signed(32'(lr))),
                                            longint'($signed(32'(gl))),
                                            longint'($signed(32'(gr)))));
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_targets.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 31'(v);
        @(posedge clk);
        regs[idx] = (idx == tpts_pkg::REG_YAW_GAIN || idx == tpts_pkg::REG_LOAD_GAIN ||
                     idx == tpts_pkg::REG_CONS_BLEND)
                    ? (v & 64'hFFFF) : (v & 64'h7FFF_FFFF);
    endtask

    task automatic load_regs(longint yg, longint yl, longint yd, longint lt,
                             longint lg, longint ll, longint ct, longint cb);
        drain();
        write_reg(tpts_pkg::REG_YAW_GAIN, yg);
        write_reg(tpts_pkg::REG_YAW_LIMIT, yl);
        write_reg(tpts_pkg::REG_YAW_DEADBAND, yd);
        write_reg(tpts_pkg::REG_LOAD_THRESHOLD, lt);
        write_reg(tpts_pkg::REG_LOAD_GAIN, lg);
        write_reg(tpts_pkg::REG_LOAD_LIMIT, ll);
        write_reg(tpts_pkg::REG_CONS_THRESHOLD, ct);
        write_reg(tpts_pkg::REG_CONS_BLEND, cb);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic longint rand_q();
        case ($urandom_range(0, 9))
            0, 1:    return longint'($signed(32'($urandom())));
            2:       return $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
            3:       return longint'($urandom_range(0, 65536)) - 32768;
            default: return longint'($urandom_range(0, 8388608)) - 4194304;
        endcase
    endfunction

    task automatic test_directed();
        longint mx, mn;
        mx = 64'sd2147483647;
        mn = -64'sd2147483648;
        // drift saturation, straight at speed
        send_tick(CMD_TICK, mx, mn, 0, 0, 200000, 200000);
        send_tick(CMD_TICK, mx, mn, 0, 0, 200000, 200000);
        send_tick(CMD_TICK, mn, mx, 0, 0, -200000, -200000);
        send_tick(CMD_SOFTRST, 5, 6, 7, 8, mx, mn);
        send_tick(CMD_TICK, mn, mx, mx, mn, mn, mn);
        // stopped, then turning
        send_tick(CMD_TICK, 100000, 0, 0, 0, 32768, -32768);
        send_tick(CMD_TICK, 100000, 0, 0, 0, 0, 0);
        send_tick(CMD_TICK, 0, 0, 900000, 0, 300000, 100000);
        send_tick(CMD_TICK, 0, 0, 0, 900000, -300000, 100000);
        // equal loads and equal errors
        send_tick(CMD_TICK, 0, 0, 1000000, 1000000, 100000, 100000);
        send_tick(CMD_TICK, 2000000, 0, 0, 0, 1000000, 1000000);
        send_tick(CMD_TICK, 0, 2000000, mn, mx, 1000000, 1000000);
        send_tick(CMD_TICK, 3000000, 0, 0, 0, 1500000, 1500000);
        // drift going negative with zero excess
        send_tick(CMD_SOFTRST, 0, 0, 0, 0, 0, 0);
        send_tick(CMD_TICK, -3000000, 0, 0, 0, 100000, 100000);
        send_tick(CMD_TICK, mx, 0, mx, mn, mx, mx);
        send_tick(CMD_TICK, mn, 0, mn, mx, mn, mn);
        drain();
    endtask

    task automatic test_direction_guard();
        load_regs(65535, 64'h7FFF_FFFF, 0, 0, 65535, 64'h7FFF_FFFF, 0, 65535);
        send_tick(CMD_TICK, 50000000, -50000000, 0, 0, 40000, 40000);
        send_tick(CMD_TICK, -50000000, 50000000, 900000000, -900000000, -40000, -40000);
        send_tick(CMD_TICK, 0, 0, -900000000, 900000000, 2000000000, 2000000000);
        send_tick(CMD_TICK, 90000000, 0, 0, 0, 64'sd2147483647, 64'sd2147483647);
        drain();
    endtask

    task automatic test_random(int count);
        longint g, sl;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_tick(CMD_SOFTRST, rand_q(), rand_q(), rand_q(), rand_q(),
                          rand_q(), rand_q());
            end else if ($urandom_range(0, 3) != 0) begin
                // straight driving: close goals, noisy speeds
                g = longint'($urandom_range(0, 4000000)) - 2000000;
                sl = g + longint'($urandom_range(0, 3000000)) - 1500000;
                send_tick(CMD_TICK, sl, sl - (longint'($urandom_range(0, 4000000)) - 2000000),
                          rand_q(), rand_q(), g,
                          g + longint'($urandom_range(0, 131072)) - 65536);
            end else begin
                send_tick(CMD_TICK, rand_q(), rand_q(), rand_q(), rand_q(),
                          rand_q(), rand_q());
            end
            if (i == count / 2) begin
                // hold off until every result is back
                in_ch.valid <= 1'b0;
                @(posedge clk);
                while (pending_targets.size() != 0) @(posedge clk);
            end
        end
        drain();
    endtask

    task automatic test_config_sweep();
        load_regs(0, 0, 0, 0, 0, 0, 0, 0);
        test_random(150);
        load_regs(65535, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 65535,
                  64'h7FFF_FFFF, 64'h7FFF_FFFF, 65535);
        test_random(120);
        steady = 1;
        load_regs(65535, 400000, 0, 100000, 65535, 300000, 500000, 40000);
        test_random(150);
        steady = 0;
        load_regs($urandom_range(0, 65535), $urandom(), $urandom_range(0, 2000000),
                  $urandom_range(0, 3000000), $urandom_range(0, 65535),
                  $urandom(), $urandom_range(0, 4000000), $urandom_range(0, 65535));
        test_random(150);
        load_regs(328, 131072, 327680, 655360, 655, 131072, 1310720, 13107);
        test_random(150);
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        steady = 0;
        drift_acc = 0;
        regs = '{328, 131072, 327680, 655360, 655, 131072, 1310720, 13107};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_random(200);
        test_directed();
        test_direction_guard();
        test_config_sweep();

        if (err_count == 0)
            $display("tb_track_pair_target_stabilizer_unit: PASS");
        else
            $display("tb_track_pair_target_stabilizer_unit: FAIL");
        $finish;
    end

endmodule

FILE: track_pair_target_stabilizer_unit.f
src/tpts_pkg.sv
src/tpts_if.sv
src/tpts_scaler.sv
src/tpts_core.sv
src/track_pair_target_stabilizer_unit.sv
tb/sv/tb_track_pair_target_stabilizer_unit.sv
